/* hw/rtl/pmpc_pkg.sv */
// Shared types, constants and codes for the PRBS memory pattern checker.
`default_nettype none

package pmpc_pkg;

	localparam int unsigned MAX_WORDS = 33554432;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ACT_W  = 2;
	localparam int unsigned WW_W   = 2;
	localparam int unsigned TW_W   = 26;
	localparam int unsigned IDX_W  = 25;
	localparam int unsigned ERR_W  = 26;
	localparam int unsigned CFG_IDX_W = 2;

	localparam longint unsigned ERR_MAX = (64'd1 << ERR_W) - 64'd1;
	localparam logic [ERR_W-1:0] ERR_LIMIT =
		ERR_W'((longint'(MAX_WORDS) > ERR_MAX) ? ERR_MAX : longint'(MAX_WORDS));
	localparam logic [ERR_W-1:0] REPORT_LIMIT = ERR_W'(4);

	localparam logic [DATA_W-1:0] SEED_RESET = DATA_W'(100500);
	localparam logic [TW_W-1:0]   TEST_WORDS_RESET = TW_W'(1024);

	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

	localparam int unsigned M_TDATA_W = ((DATA_W + IDX_W + ERR_W + 7) / 8) * 8;

	localparam logic [ACT_W-1:0] ACT_RESTART = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CHECK   = 2'd2;

	localparam logic [WW_W-1:0] WW_8  = 2'd0;
	localparam logic [WW_W-1:0] WW_16 = 2'd1;
	localparam logic [WW_W-1:0] WW_32 = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_WORD_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEST_WORDS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SEED = 2'd2;

	typedef enum logic [1:0] {
		KIND_RESTART,
		KIND_WRITE,
		KIND_CHECK,
		KIND_NOP
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [DATA_W-1:0] read_data;
	} item_t;

	typedef struct packed {
		logic [WW_W-1:0]   word_width;
		logic [TW_W-1:0]   test_words;
		logic [DATA_W-1:0] start_seed;
	} cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/pmpc_front.sv */
// Front end: accept input transfers, decode the action and queue the items.
`default_nettype none

module pmpc_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [pmpc_pkg::DATA_W-1:0]   s_tdata,
	input  wire logic [pmpc_pkg::ACT_W-1:0]    s_tuser,
	output logic                               q_valid,
	output pmpc_pkg::item_t                    q_item,
	input  wire logic                          q_pop
);

	pmpc_pkg::item_t                    entry_q [pmpc_pkg::QDEPTH];
	logic [pmpc_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [pmpc_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [pmpc_pkg::QCNT_W-1:0]        count_q;
	pmpc_pkg::item_t                    item_in;
	logic                               push;
	logic                               pop;

	always_comb begin
		item_in.read_data = s_tdata;
		case (s_tuser)
			pmpc_pkg::ACT_RESTART: item_in.kind = pmpc_pkg::KIND_RESTART;
			pmpc_pkg::ACT_WRITE:   item_in.kind = pmpc_pkg::KIND_WRITE;
			pmpc_pkg::ACT_CHECK:   item_in.kind = pmpc_pkg::KIND_CHECK;
			default:               item_in.kind = pmpc_pkg::KIND_NOP;
		endcase
	end

	assign s_tready = (count_q != pmpc_pkg::QCNT_W'(pmpc_pkg::QDEPTH));
	assign q_valid  = (count_q != '0);
	assign q_item   = entry_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/pmpc_back.sv */
// Back end: pattern sequence, counters, compare and the output register.
`default_nettype none

module pmpc_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire pmpc_pkg::cfg_t                    cfg,
	input  wire logic                              q_valid,
	input  wire pmpc_pkg::item_t                   q_item,
	output logic                                   q_pop,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [pmpc_pkg::DATA_W-1:0]            pattern_word,
	output logic [pmpc_pkg::IDX_W-1:0]             word_index,
	output logic                                   mismatch,
	output logic                                   report_error,
	output logic [pmpc_pkg::ERR_W-1:0]             error_total,
	output logic                                   last_word
);

	logic [pmpc_pkg::DATA_W-1:0] lfsr_q;
	logic [pmpc_pkg::IDX_W-1:0]  word_cnt_q;
	logic [pmpc_pkg::ERR_W-1:0]  err_cnt_q;
	logic                        out_valid_q;

	logic [pmpc_pkg::DATA_W-1:0] mask;
	logic [pmpc_pkg::DATA_W-1:0] pat;
	logic [pmpc_pkg::DATA_W-1:0] lfsr_adv;
	logic [pmpc_pkg::TW_W-1:0]   n_cap;
	logic [pmpc_pkg::TW_W-1:0]   n_cap_m1;
	logic                        is_last;
	logic                        diff;
	logic [pmpc_pkg::ERR_W-1:0]  err_upd;
	logic                        take;

	logic [pmpc_pkg::DATA_W-1:0] lfsr_d;
	logic [pmpc_pkg::IDX_W-1:0]  word_cnt_d;
	logic [pmpc_pkg::ERR_W-1:0]  err_cnt_d;
	logic [pmpc_pkg::DATA_W-1:0] pat_d;
	logic [pmpc_pkg::IDX_W-1:0]  idx_d;
	logic                        mis_d;
	logic                        rep_d;
	logic [pmpc_pkg::ERR_W-1:0]  tot_d;
	logic                        last_d;

	assign take  = q_valid && (!out_valid_q || m_tready);
	assign q_pop = take;

	always_comb begin
		case (cfg.word_width)
			pmpc_pkg::WW_8:  mask = pmpc_pkg::DATA_W'(32'h0000_00FF);
			pmpc_pkg::WW_16: mask = pmpc_pkg::DATA_W'(32'h0000_FFFF);
			default:         mask = '1;
		endcase
	end

	assign pat      = lfsr_q & mask;
	assign lfsr_adv = {lfsr_q[30:0], lfsr_q[31] ^ lfsr_q[30] ^ lfsr_q[4] ^ lfsr_q[3]};
	assign diff     = (q_item.kind == pmpc_pkg::KIND_CHECK) &&
		((q_item.read_data & mask) != pat);

	always_comb begin
		if (32'(cfg.test_words) > pmpc_pkg::MAX_WORDS) begin
			n_cap = pmpc_pkg::TW_W'(pmpc_pkg::MAX_WORDS);
		end else begin
			n_cap = cfg.test_words;
		end
	end

	assign n_cap_m1 = n_cap - 1'b1;
	assign is_last  = (n_cap != '0) && (word_cnt_q == n_cap_m1[pmpc_pkg::IDX_W-1:0]);
	assign err_upd  = (diff && (err_cnt_q < pmpc_pkg::ERR_LIMIT)) ? err_cnt_q + 1'b1 : err_cnt_q;

	always_comb begin
		lfsr_d     = lfsr_q;
		word_cnt_d = word_cnt_q;
		err_cnt_d  = err_cnt_q;
		pat_d      = '0;
		idx_d      = '0;
		mis_d      = 1'b0;
		rep_d      = 1'b0;
		tot_d      = '0;
		last_d     = 1'b0;
		case (q_item.kind)
			pmpc_pkg::KIND_RESTART: begin
				lfsr_d     = cfg.start_seed;
				word_cnt_d = '0;
				err_cnt_d  = '0;
			end
			pmpc_pkg::KIND_WRITE, pmpc_pkg::KIND_CHECK: begin
				lfsr_d     = lfsr_adv;
				word_cnt_d = word_cnt_q + 1'b1;
				err_cnt_d  = err_upd;
				pat_d      = pat;
				idx_d      = word_cnt_q;
				mis_d      = diff;
				rep_d      = diff && (err_upd <= pmpc_pkg::REPORT_LIMIT);
				tot_d      = err_upd;
				last_d     = is_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q      <= pmpc_pkg::SEED_RESET;
			word_cnt_q  <= '0;
			err_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				lfsr_q     <= lfsr_d;
				word_cnt_q <= word_cnt_d;
				err_cnt_q  <= err_cnt_d;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pattern_word <= pat_d;
			word_index   <= idx_d;
			mismatch     <= mis_d;
			report_error <= rep_d;
			error_total  <= tot_d;
			last_word    <= last_d;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/prbs_memory_pattern_checker.sv */
// Top level of the PRBS memory pattern checker.
`default_nettype none

// Generates the 32-bit pseudo-random pattern for a memory test and checks
// read-back words against it. Each input transfer carries an action in
// s_tuser (restart, write, check, no-op) and read data in s_tdata; each one
// yields exactly one result transfer. One item is taken per clock cycle while
// the output is not stalled. A result is registered in the four-entry decode
// queue, then in the output register of the execute stage, whose sequence
// advance and error count update set the rate. The queue and the output
// register let input and output stall independently. Configuration writes
// (word width, region size, seed) must be made by the user while no item is
// in flight (not enforced); a new seed takes effect at the next restart.
module prbs_memory_pattern_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// read_data [31:0]
	input  wire logic [pmpc_pkg::DATA_W-1:0]        s_tdata,
	// action [1:0]
	input  wire logic [pmpc_pkg::ACT_W-1:0]         s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// pattern_word [31:0], word_index [56:32], error_total [82:57], zero [87:83]
	output logic [pmpc_pkg::M_TDATA_W-1:0]          m_tdata,
	// mismatch [0], report_error [1]
	output logic [1:0]                              m_tuser,
	output logic                                    m_tlast,
	input  wire logic                               cfg_we,
	input  wire logic [pmpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pmpc_pkg::DATA_W-1:0]        cfg_wdata
);

	pmpc_pkg::cfg_t                  cfg_q;
	logic                            q_valid;
	pmpc_pkg::item_t                 q_item;
	logic                            q_pop;
	logic [pmpc_pkg::DATA_W-1:0]     pattern_word;
	logic [pmpc_pkg::IDX_W-1:0]      word_index;
	logic [pmpc_pkg::ERR_W-1:0]      error_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.word_width <= pmpc_pkg::WW_32;
			cfg_q.test_words <= pmpc_pkg::TEST_WORDS_RESET;
			cfg_q.start_seed <= pmpc_pkg::SEED_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pmpc_pkg::CFG_WORD_WIDTH: cfg_q.word_width <= cfg_wdata[pmpc_pkg::WW_W-1:0];
				pmpc_pkg::CFG_TEST_WORDS: cfg_q.test_words <= cfg_wdata[pmpc_pkg::TW_W-1:0];
				pmpc_pkg::CFG_START_SEED: cfg_q.start_seed <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	pmpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	pmpc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.pattern_word (pattern_word),
		.word_index   (word_index),
		.mismatch     (m_tuser[0]),
		.report_error (m_tuser[1]),
		.error_total  (error_total),
		.last_word    (m_tlast)
	);

	assign m_tdata = {
		(pmpc_pkg::M_TDATA_W - pmpc_pkg::DATA_W - pmpc_pkg::IDX_W - pmpc_pkg::ERR_W)'(0),
		error_total, word_index, pattern_word
	};

endmodule

`default_nettype wire

/* hw/rtl/pmpc_checker.sv */
// Port-level assertions for the PRBS memory pattern checker, bound to the top.
`default_nettype none

module pmpc_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               m_tvalid,
	input wire logic                               m_tready,
	input wire logic [pmpc_pkg::M_TDATA_W-1:0]     m_tdata,
	input wire logic [1:0]                         m_tuser,
	input wire logic                               m_tlast
);

	logic [pmpc_pkg::ERR_W-1:0] total;

	assign total = m_tdata[pmpc_pkg::DATA_W + pmpc_pkg::IDX_W +: pmpc_pkg::ERR_W];

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_report_is_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("report without mismatch");

	a_mismatch_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> total != '0)
		else $error("mismatch with zero error count");

	a_report_early: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> total <= pmpc_pkg::REPORT_LIMIT)
		else $error("report beyond the first mismatches");

	a_last_needs_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tuser[0] |-> total != '0)
		else $error("last word mismatch with zero error count");

endmodule

bind prbs_memory_pattern_checker pmpc_checker u_pmpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

/* dv/tb_prbs_memory_pattern_checker.sv */
// Testbench for the PRBS memory pattern checker: streams actions, predicts each result, compares.
`default_nettype none

module tb_prbs_memory_pattern_checker;

	import pmpc_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned IDLE_PCT    = 34;

	typedef struct packed {
		logic [DATA_W-1:0] pattern_word;
		logic [IDX_W-1:0]  word_index;
		logic [ERR_W-1:0]  error_total;
		logic              mismatch;
		logic              report_error;
		logic              last_word;
	} word_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [DATA_W-1:0]      s_tdata = '0;
	logic [ACT_W-1:0]       s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [1:0]             m_tuser;
	logic                   m_tlast;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [DATA_W-1:0]      cfg_wdata = '0;

	// configuration as last written
	logic [WW_W-1:0]        cfg_width = WW_32;
	logic [TW_W-1:0]        cfg_words = TEST_WORDS_RESET;
	logic [DATA_W-1:0]      cfg_seed  = SEED_RESET;

	// pattern engine state as the block should hold it
	logic [DATA_W-1:0]      prbs_q   = SEED_RESET;
	logic [IDX_W-1:0]       word_cnt = '0;
	logic [ERR_W-1:0]       err_cnt  = '0;

	// sequence position of the stimulus generator, used to build good reads
	logic [DATA_W-1:0]      gen_prbs = SEED_RESET;

	item_t                  item_backlog[$];
	word_result_t           pending_results[$];
	item_t                  drive_item;
	word_result_t           want;

	bit                     in_taken;
	bit                     out_taken;
	bit                     no_idle;
	int unsigned            n_queued;
	int unsigned            n_accepted;
	int unsigned            n_checked;
	int unsigned            n_reports;
	int unsigned            n_last;
	int unsigned            n_cfg;
	int unsigned            fail_cnt;
	int unsigned            idle_cycles;

	prbs_memory_pattern_checker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic [DATA_W-1:0] prbs_advance(logic [DATA_W-1:0] x);
		return {x[30:0], x[31] ^ x[30] ^ x[4] ^ x[3]};
	endfunction

	function automatic logic [DATA_W-1:0] access_mask(logic [WW_W-1:0] w);
		case (w)
			WW_8:    return 32'h0000_00FF;
			WW_16:   return 32'h0000_FFFF;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic word_result_t next_result(kind_t kind, logic [DATA_W-1:0] rd);
		word_result_t r;
		logic [DATA_W-1:0] m;
		logic [TW_W-1:0] region;
		r = '0;
		m = access_mask(cfg_width);
		case (kind)
			KIND_RESTART: begin
				prbs_q = cfg_seed;
				word_cnt = '0;
				err_cnt = '0;
			end
			KIND_WRITE, KIND_CHECK: begin
				r.pattern_word = prbs_q & m;
				r.word_index = word_cnt;
				if (kind == KIND_CHECK && (rd & m) != r.pattern_word) begin
					r.mismatch = 1'b1;
					if (err_cnt < ERR_LIMIT)
						err_cnt = err_cnt + 1'b1;
					r.report_error = (err_cnt <= REPORT_LIMIT);
				end
				r.error_total = err_cnt;
				region = (cfg_words > MAX_WORDS) ? TW_W'(MAX_WORDS) : cfg_words;
				r.last_word = (region != '0) && (word_cnt == IDX_W'(region - 1'b1));
				prbs_q = prbs_advance(prbs_q);
				word_cnt = word_cnt + 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			fail_cnt++;
		end
	endfunction

	function automatic void queue_item(kind_t kind, logic [DATA_W-1:0] data);
		item_t it;
		it.kind = kind;
		it.read_data = data;
		item_backlog.push_back(it);
		n_queued++;
		case (kind)
			KIND_RESTART:           gen_prbs = cfg_seed;
			KIND_WRITE, KIND_CHECK: gen_prbs = prbs_advance(gen_prbs);
			default: ;
		endcase
	endfunction

	function automatic void queue_check(bit bad);
		logic [DATA_W-1:0] m;
		logic [DATA_W-1:0] flip;
		int unsigned nbits;
		m = access_mask(cfg_width);
		nbits = (m == 32'h0000_00FF) ? 8 : (m == 32'h0000_FFFF) ? 16 : 32;
		flip = ($urandom_range(1) ? $urandom : 32'd0) | (32'd1 << ($urandom_range(31) % nbits));
		queue_check_data: begin
			queue_item(KIND_CHECK,
				((gen_prbs ^ (bad ? flip : 32'd0)) & m) | ($urandom & ~m));
		end
	endfunction

	// write a whole region, then restart and read it back
	function automatic void queue_region(int unsigned words, int unsigned bad_pct);
		queue_item(KIND_RESTART, $urandom);
		for (int unsigned i = 0; i < words; i++)
			queue_item(KIND_WRITE, $urandom);
		queue_item(KIND_RESTART, $urandom);
		for (int unsigned i = 0; i < words; i++)
			queue_check($urandom_range(99) < bad_pct);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_WORD_WIDTH: cfg_width = val[WW_W-1:0];
			CFG_TEST_WORDS: cfg_words = val[TW_W-1:0];
			CFG_START_SEED: cfg_seed = val;
			default: ;
		endcase
		n_cfg++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || pending_results.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!s_tvalid || in_taken) begin
			if (arst_n && item_backlog.size() != 0 &&
			    (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
				drive_item = item_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= drive_item.read_data;
				s_tuser <= drive_item.kind;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		in_taken = arst_n && s_tvalid && s_tready;
		out_taken = arst_n && m_tvalid && m_tready;
		if (in_taken) begin
			pending_results.push_back(next_result(kind_t'(s_tuser), s_tdata));
			n_accepted++;
		end
		if (out_taken) begin
			n_checked++;
			if (pending_results.size() == 0) begin
				$error("result transfer with no prediction pending");
				fail_cnt++;
			end else begin
				want = pending_results.pop_front();
				check_field("pattern_word", want.pattern_word, m_tdata[31:0]);
				check_field("word_index", 32'(want.word_index), 32'(m_tdata[56:32]));
				check_field("error_total", 32'(want.error_total), 32'(m_tdata[82:57]));
				check_field("mismatch", 32'(want.mismatch), 32'(m_tuser[0]));
				check_field("report_error", 32'(want.report_error), 32'(m_tuser[1]));
				check_field("last_word", 32'(want.last_word), 32'(m_tlast));
				n_reports += want.report_error;
				n_last += want.last_word;
			end
		end
		if (in_taken || out_taken)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned base;
		int unsigned bad_pct;
		int unsigned words;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset configuration: 32-bit words, reset seed, report limit
		queue_item(KIND_WRITE, $urandom);
		queue_check(1'b0);
		repeat (5) queue_check(1'b1);
		queue_item(KIND_NOP, $urandom);
		queue_item(KIND_RESTART, $urandom);
		queue_check(1'b1);
		queue_item(KIND_CHECK, 32'h0000_0000);
		queue_item(KIND_CHECK, 32'hFFFF_FFFF);
		wait_drained();

		// byte width, three-word region with overrun, all-zero seed
		write_reg(CFG_WORD_WIDTH, 32'(WW_8));
		write_reg(CFG_TEST_WORDS, 32'd3);
		write_reg(CFG_START_SEED, 32'h0000_0000);
		cfg_we <= 1'b0;
		queue_item(KIND_RESTART, $urandom);
		repeat (4) queue_item(KIND_WRITE, $urandom);
		repeat (2) queue_check(1'b0);
		wait_drained();

		// halfword width, empty region, new seed before restart
		write_reg(CFG_WORD_WIDTH, 32'(WW_16));
		write_reg(CFG_TEST_WORDS, 32'd0);
		write_reg(CFG_START_SEED, 32'hFFFF_FFFF);
		cfg_we <= 1'b0;
		queue_check(1'b0);
		queue_item(KIND_RESTART, $urandom);
		repeat (2) queue_item(KIND_WRITE, $urandom);
		queue_check(1'b1);
		wait_drained();

		// unused width code, oversized region
		write_reg(CFG_WORD_WIDTH, 32'd3);
		write_reg(CFG_TEST_WORDS, 32'h03FF_FFFF);
		cfg_we <= 1'b0;
		queue_item(KIND_RESTART, $urandom);
		repeat (2) queue_item(KIND_WRITE, $urandom);
		queue_check(1'b0);

		for (int unsigned phase = 0; phase < 10; phase++) begin
			wait_drained();
			if (phase == 0 || $urandom_range(9) < 7)
				write_reg(CFG_WORD_WIDTH, $urandom_range(3));
			if (phase == 0 || $urandom_range(9) < 7) begin
				case ($urandom_range(9))
					0:       write_reg(CFG_TEST_WORDS, 32'd0);
					1:       write_reg(CFG_TEST_WORDS, 32'h03FF_FFFF);
					2:       write_reg(CFG_TEST_WORDS, MAX_WORDS);
					3:       write_reg(CFG_TEST_WORDS, $urandom_range(32'h03FF_FFFF));
					default: write_reg(CFG_TEST_WORDS, $urandom_range(1, 24));
				endcase
			end
			if ($urandom_range(9) < 7)
				write_reg(CFG_START_SEED, $urandom_range(9) == 0 ? 32'hFFFF_FFFF : $urandom);
			cfg_we <= 1'b0;
			no_idle = (phase == 4);
			bad_pct = $urandom_range(30);
			base = n_queued;
			while (n_queued - base < 100) begin
				if ($urandom_range(9) < 7) begin
					if (cfg_words != 0 && cfg_words <= 24 && $urandom_range(1))
						words = cfg_words + $urandom_range(2);
					else
						words = $urandom_range(1, 20);
					queue_region(words, bad_pct);
				end else begin
					repeat ($urandom_range(1, 8))
						queue_item(kind_t'($urandom_range(3)), $urandom);
				end
			end
		end

		wait_drained();
		repeat (10) @(negedge clk);
		$display("Run: %0d transfers in, %0d results checked, %0d register writes",
			n_accepted, n_checked, n_cfg);
		$display("Run: %0d mismatches flagged for report, %0d region-end words",
			n_reports, n_last);
		if (fail_cnt == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/pmpc_pkg.sv
hw/rtl/pmpc_front.sv
hw/rtl/pmpc_back.sv
hw/rtl/prbs_memory_pattern_checker.sv
hw/rtl/pmpc_checker.sv
dv/tb_prbs_memory_pattern_checker.sv
